FILE: sv/pcg_pkg.sv
// Package: shared types, constants and functions of the PCG32 bounded generator.
package pcg_pkg;

    localparam logic [63:0] LCG_MULT            = 64'd6364136223846793005;
    localparam logic [63:0] RESET_SEED_STATE    = 64'h853c49e6748fea9b;
    localparam logic [63:0] RESET_SEED_SEQUENCE = 64'hda3e39cb94b95bdb;
    localparam int          QUEUE_DEPTH         = 2;
    localparam int          PADDR_W             = 4;

    localparam logic [PADDR_W-1:0] ADDR_SEED_STATE    = 4'h0;
    localparam logic [PADDR_W-1:0] ADDR_SEED_SEQUENCE = 4'h8;

    typedef enum logic [1:0] {
        FUNC_RAW      = 2'd0,
        FUNC_UNBIASED = 2'd1,
        FUNC_FAST     = 2'd2,
        FUNC_SPARE    = 2'd3
    } func_t;

    // classified request passed from front to back
    typedef enum logic [1:0] {
        OP_RAW,
        OP_CONST,
        OP_UNBIASED,
        OP_FAST
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] low_bound;
        logic [31:0] bound;
    } job_t;

    typedef enum logic [3:0] {
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_IDLE,
        ST_THR_DIV,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_SUM,
        ST_CHECK,
        ST_MOD_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [32:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    function automatic logic [31:0] pcg_output(input logic [63:0] old);
        logic [31:0] xs;
        logic [4:0]  rot;
        xs  = 32'(((old >> 18) ^ old) >> 27);
        rot = old[63:59];
        return (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    endfunction

endpackage

FILE: sv/pcg_if.sv
// Interfaces: request and result channels of the generator.
interface pcg_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    modport source (output valid, func, low_bound, high_bound, input ready);
    modport sink (input valid, func, low_bound, high_bound, output ready);
endinterface

interface pcg_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] random_value;
    modport source (output valid, random_value, input ready);
    modport sink (input valid, random_value, output ready);
endinterface

FILE: sv/pcg_front.sv
// Front: accepts requests, classifies them and queues the resulting jobs.
module pcg_front
    import pcg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pcg_req_if.sink  req,
    output logic     job_valid,
    output job_t     job,
    input  logic     job_take
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    job_t             job_in;
    logic             push;
    logic             pop;

    always_comb
    begin
        job_in.low_bound = req.low_bound;
        job_in.bound     = req.high_bound - req.low_bound;
        unique case (func_t'(req.func))
            FUNC_UNBIASED: job_in.op = (req.low_bound == req.high_bound) ? OP_CONST : OP_UNBIASED;
            FUNC_FAST:     job_in.op = (req.low_bound == req.high_bound) ? OP_CONST : OP_FAST;
            default:       job_in.op = OP_RAW;
        endcase
    end

    assign req.ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_take && job_valid;
    assign job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH) : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/pcg_div.sv
// Divider: restoring remainder unit, one quotient bit per cycle.
module pcg_div
    import pcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    dreq,
    output logic        done,
    output logic [31:0] remainder
);

    logic [32:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] trial;

    assign done      = busy_reg && (cnt_reg == 6'd0);
    assign remainder = rem_reg[31:0];

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, num_reg[32]} - {2'b00, dvs_reg};
        if (dreq.start)
        begin
            num_next  = dreq.dividend;
            rem_next  = '0;
            dvs_next  = dreq.divisor;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            num_next = {num_reg[31:0], 1'b0};
            rem_next = trial[33] ? {rem_reg[31:0], num_reg[32]} : trial[32:0];
            cnt_next = cnt_reg - 6'd1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

FILE: sv/pcg_back.sv
// Back: holds the generator state, seeds it, runs jobs and drives results.
module pcg_back
    import pcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        reseed,
    input  logic [63:0] seed_state,
    input  logic [63:0] seed_sequence,
    input  logic        job_valid,
    input  job_t        job,
    output logic        job_take,
    pcg_res_if.source   res
);

    state_t      st_reg, st_next;
    logic [63:0] gen_reg, gen_next;
    logic [63:0] acc_reg, acc_next;
    job_t        cur_reg, cur_next;
    logic [31:0] thr_reg, thr_next;
    logic [31:0] rnd_reg, rnd_next;
    logic [31:0] out_reg, out_next;
    logic        ov_reg, ov_next;
    logic [63:0] inc;
    logic [63:0] prod;
    div_req_t    dreq;
    logic        ddone;
    logic [31:0] drem;
    logic        out_free;

    pcg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .dreq      (dreq),
        .done      (ddone),
        .remainder (drem)
    );

    assign inc          = {seed_sequence[62:0], 1'b1};
    assign res.valid    = ov_reg;
    assign res.random_value = out_reg;
    assign out_free     = !ov_reg || res.ready;

    // one 32x32 partial product per cycle
    always_comb
    begin
        unique case (st_reg)
            ST_MUL_LL: prod = 64'(gen_reg[31:0]) * 64'(LCG_MULT[31:0]);
            ST_MUL_LH: prod = 64'(gen_reg[31:0]) * 64'(LCG_MULT[63:32]);
            ST_MUL_HL: prod = 64'(gen_reg[63:32]) * 64'(LCG_MULT[31:0]);
            default:   prod = '0;
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_SEED_MUL: st_next = ST_MUL_LL;
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    unique case (job.op)
                        OP_CONST:    st_next = ST_OUT;
                        OP_UNBIASED: st_next = ST_THR_DIV;
                        default:     st_next = ST_MUL_LL;
                    endcase
                end
            end
            ST_THR_DIV:  st_next = ddone ? ST_MUL_LL : ST_THR_DIV;
            ST_MUL_LL:   st_next = ST_MUL_LH;
            ST_MUL_LH:   st_next = ST_MUL_HL;
            ST_MUL_HL:   st_next = ST_MUL_SUM;
            ST_MUL_SUM:  st_next = ST_CHECK;
            ST_SEED_ADD: st_next = ST_MUL_LL;
            ST_CHECK:
            begin
                priority if (acc_reg[0])
                    st_next = ST_SEED_ADD;
                else if (acc_reg[1])
                    st_next = ST_IDLE;
                else if (cur_reg.op == OP_RAW)
                    st_next = ST_OUT;
                else if (cur_reg.op == OP_UNBIASED && rnd_reg < thr_reg)
                    st_next = ST_MUL_LL;
                else
                    st_next = ST_MOD_DIV;
            end
            ST_MOD_DIV:  st_next = ddone ? ST_OUT : ST_MOD_DIV;
            ST_OUT:      st_next = out_free ? ST_IDLE : ST_OUT;
            default:     st_next = ST_IDLE;
        endcase
        if (reseed)
        begin
            st_next = ST_SEED_MUL;
        end
    end

    // acc_reg[1:0] doubles as seed phase flags in ST_CHECK: bit0 first seed step, bit1 second
    always_comb
    begin
        gen_next = gen_reg;
        acc_next = acc_reg;
        cur_next = cur_reg;
        thr_next = thr_reg;
        rnd_next = rnd_reg;
        out_next = out_reg;
        ov_next  = ov_reg && !res.ready;
        job_take = 1'b0;
        dreq     = '0;
        unique case (st_reg)
            ST_SEED_MUL:
            begin
                gen_next = '0;
                cur_next.op = OP_CONST;
            end
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    cur_next = job;
                    if (job.op == OP_UNBIASED)
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = {1'b1, 32'd0} - {1'b0, job.bound};
                        dreq.divisor  = job.bound;
                    end
                end
            end
            ST_THR_DIV:  thr_next = drem;
            ST_MUL_LL:
            begin
                rnd_next = pcg_output(gen_reg);
                acc_next = prod + inc;
            end
            ST_MUL_LH:   acc_next = acc_reg + {prod[31:0], 32'd0};
            ST_MUL_HL:   acc_next = acc_reg + {prod[31:0], 32'd0};
            ST_MUL_SUM:
            begin
                gen_next = acc_reg;
                acc_next = '0;
                if (cur_reg.op == OP_CONST)
                begin
                    acc_next = (thr_reg == 32'd0) ? 64'd1 : 64'd2;
                end
            end
            ST_SEED_ADD:
            begin
                gen_next = gen_reg + seed_state;
                thr_next = 32'd1;
            end
            ST_CHECK:
            begin
                if (acc_reg[1])
                begin
                    thr_next = '0;
                end
                else if (!acc_reg[0])
                begin
                    if (cur_reg.op != OP_RAW
                        && !(cur_reg.op == OP_UNBIASED && rnd_reg < thr_reg))
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = {1'b0, rnd_reg};
                        dreq.divisor  = cur_reg.bound;
                    end
                end
            end
            ST_MOD_DIV:  rnd_next = cur_reg.low_bound + drem;
            ST_OUT:
            begin
                if (out_free)
                begin
                    ov_next  = 1'b1;
                    out_next = (cur_reg.op == OP_CONST) ? cur_reg.low_bound : rnd_reg;
                end
            end
            default: ;
        endcase
        if (reseed)
        begin
            thr_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        cur_reg <= cur_next;
        rnd_reg <= rnd_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_SEED_MUL;
            gen_reg <= '0;
            thr_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            gen_reg <= gen_next;
            thr_reg <= thr_next;
            ov_reg  <= ov_next;
        end
    end

endmodule

FILE: sv/pcg32_bounded_random_generator_top.sv
// Top level: PCG32 XSH-RR generator with bounded-range requests.
// Flow: the back runs one request at a time through a bit-serial divider and a split
//   64-bit LCG multiply; the front queues up to two further requests meanwhile.
// Reset: asynchronous active low; seed registers take their reset values and the
//   generator seeds itself; requests queue meanwhile.
module pcg32_bounded_random_generator_top
    import pcg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    pcg_req_if.sink            req,
    pcg_res_if.source          res
);

    logic [63:0] seed_state_reg;
    logic [63:0] seed_sequence_reg;
    logic        wr;
    logic        reseed;
    logic        job_valid;
    logic        job_take;
    job_t        job;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign reseed = wr && (paddr == ADDR_SEED_STATE || paddr == ADDR_SEED_SEQUENCE);

    always_comb
    begin
        unique case (paddr)
            ADDR_SEED_STATE:    prdata = seed_state_reg;
            ADDR_SEED_SEQUENCE: prdata = seed_sequence_reg;
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_state_reg    <= RESET_SEED_STATE;
            seed_sequence_reg <= RESET_SEED_SEQUENCE;
        end
        else if (wr && paddr == ADDR_SEED_STATE)
        begin
            seed_state_reg <= pwdata;
        end
        else if (wr && paddr == ADDR_SEED_SEQUENCE)
        begin
            seed_sequence_reg <= pwdata;
        end
    end

    pcg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take)
    );

    pcg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .reseed        (reseed),
        .seed_state    (wr && paddr == ADDR_SEED_STATE ? pwdata : seed_state_reg),
        .seed_sequence (wr && paddr == ADDR_SEED_SEQUENCE ? pwdata : seed_sequence_reg),
        .job_valid     (job_valid),
        .job           (job),
        .job_take      (job_take),
        .res           (res)
    );

endmodule

FILE: sv/pcg_checker.sv
// Checker: port-level assertions on the generator, bound to the top level.
module pcg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_value,
    input logic        req_valid,
    input logic        req_ready
);

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value))
        else $error("result dropped or changed while stalled");

    assert property (@(posedge clk) $fell(rst_n) |-> ##1 !res_valid || !rst_n)
        else $error("result shown out of reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid straight after reset");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid)
        else $error("request withdrawn while waiting");

endmodule

bind pcg32_bounded_random_generator_top pcg_checker u_pcg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_value (res.random_value),
    .req_valid (req.valid),
    .req_ready (req.ready)
);

FILE: sim/pcg32_bounded_random_generator_top_tb.sv
// Testbench: random and directed requests to the bounded PCG32 generator, checked against a predictor.
module pcg32_bounded_random_generator_top_tb;
    import pcg_pkg::*;

    class value_board;
        logic [63:0] seed_st;
        logic [63:0] seed_seq;
        logic [63:0] gen_st;
        logic [31:0] pending[$];
        int          errors;

        function new();
            errors = 0;
            seed_st = RESET_SEED_STATE;
            seed_seq = RESET_SEED_SEQUENCE;
            reseed();
        endfunction

        function logic [31:0] lcg_advance();
            logic [63:0] old;
            logic [31:0] xs;
            logic [4:0]  rot;
            old = gen_st;
            gen_st = old * LCG_MULT + {seed_seq[62:0], 1'b1};
            xs = 32'(((old >> 18) ^ old) >> 27);
            rot = old[63:59];
            return (rot == 0) ? xs : ((xs >> rot) | (xs << (6'd32 - rot)));
        endfunction

        function void reseed();
            logic [31:0] drop;
            gen_st = '0;
            drop = lcg_advance();
            gen_st = gen_st + seed_st;
            drop = lcg_advance();
        endfunction

        function void write_seed(logic [PADDR_W-1:0] a, logic [63:0] d);
            if (a == ADDR_SEED_STATE)
            begin
                seed_st = d;
                reseed();
            end
            else if (a == ADDR_SEED_SEQUENCE)
            begin
                seed_seq = d;
                reseed();
            end
        endfunction

        function void note_request(logic [1:0] f, logic [31:0] lo, logic [31:0] hi);
            logic [31:0] span;
            logic [31:0] thr;
            logic [31:0] r;
            if ((f == FUNC_UNBIASED || f == FUNC_FAST) && lo == hi)
                pending.push_back(lo);
            else if (f == FUNC_UNBIASED)
            begin
                span = hi - lo;
                thr = (32'd0 - span) % span;
                r = lcg_advance();
                while (r < thr)
                    r = lcg_advance();
                pending.push_back(lo + r % span);
            end
            else if (f == FUNC_FAST)
            begin
                span = hi - lo;
                pending.push_back(lo + lcg_advance() % span);
            end
            else
                pending.push_back(lcg_advance());
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_value(logic [31:0] v);
            logic [31:0] want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected value %h", v));
            end
            else
            begin
                want = pending.pop_front();
                if (v !== want)
                begin
                    report($sformatf("random_value %h, want %h", v, want));
                end
            end
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;
    int tx_idle, rx_stall;
    value_board board;

    pcg_req_if req();
    pcg_res_if res();

    pcg32_bounded_random_generator_top uut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .req(req.sink), .res(res.source)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    initial
    begin
        req.valid = 0;
        req.func = '0;
        req.low_bound = '0;
        req.high_bound = '0;
        res.ready = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            board.check_value(res.random_value);
        res.ready <= ($urandom_range(99) >= rx_stall);
    end

    task automatic write_reg(logic [PADDR_W-1:0] a, logic [63:0] d);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= a;
        pwdata <= d;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.write_seed(a, d);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [1:0] f, logic [31:0] lo, logic [31:0] hi);
        while ($urandom_range(99) < tx_idle)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.func <= f;
        req.low_bound <= lo;
        req.high_bound <= hi;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(f, lo, hi);
    endtask

    task automatic drain();
        req.valid <= 0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic random_requests(int n);
        logic [31:0] lo, hi;
        logic [1:0] f;
        for (int i = 0; i < n; i++)
        begin
            f = 2'($urandom_range(3));
            lo = $urandom;
            case ($urandom_range(3))
                0: hi = lo + $urandom_range(1, 16);
                1: hi = $urandom;
                2: hi = lo - $urandom_range(1, 300);
                default: hi = ($urandom_range(9) == 0) ? lo : lo + $urandom_range(1, 1000);
            endcase
            send_request(f, lo, hi);
        end
    endtask

    initial
    begin
        board = new();
        tx_idle = 0;
        rx_stall = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_request(FUNC_RAW, 0, 0);
        send_request(FUNC_SPARE, 32'hffffffff, 32'hffffffff);
        send_request(FUNC_UNBIASED, 5, 5);
        send_request(FUNC_FAST, 32'hffffffff, 32'hffffffff);
        send_request(FUNC_UNBIASED, 0, 32'hffffffff);
        send_request(FUNC_FAST, 0, 32'hffffffff);
        send_request(FUNC_UNBIASED, 32'hffffffff, 0);
        send_request(FUNC_FAST, 32'hffffffff, 0);
        send_request(FUNC_UNBIASED, 10, 3);
        send_request(FUNC_FAST, 10, 3);
        send_request(FUNC_UNBIASED, 0, 32'h80000001);
        send_request(FUNC_UNBIASED, 0, 3);
        send_request(FUNC_UNBIASED, 0, 2);
        send_request(FUNC_FAST, 7, 8);
        send_request(FUNC_UNBIASED, 32'h12345678, 32'h92345679);
        drain();

        write_reg(ADDR_SEED_STATE, 64'h0);
        write_reg(ADDR_SEED_SEQUENCE, 64'h0);
        random_requests(60);
        drain();

        tx_idle = 86;
        write_reg(ADDR_SEED_STATE, 64'hffffffffffffffff);
        write_reg(ADDR_SEED_SEQUENCE, 64'hffffffffffffffff);
        random_requests(60);
        drain();

        tx_idle = 0;
        rx_stall = 86;
        write_reg(ADDR_SEED_SEQUENCE, {$urandom, $urandom});
        random_requests(60);
        drain();

        tx_idle = 33;
        rx_stall = 33;
        write_reg(ADDR_SEED_STATE, {$urandom, $urandom});
        random_requests(100);
        drain();

        tx_idle = 0;
        rx_stall = 0;
        write_reg(ADDR_SEED_STATE, RESET_SEED_STATE);
        write_reg(ADDR_SEED_SEQUENCE, RESET_SEED_SEQUENCE);
        random_requests(100);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
